// ----- design/piecewise_linear_penalty_lookup_core_assert.svh -----
// assertion helpers shared by the lookup core
`ifndef PIECEWISE_LINEAR_PENALTY_LOOKUP_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_PENALTY_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define PLPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/plpl_pkg.sv -----
package plpl_pkg;

	localparam int MAX_BREAKPOINTS = 16;
	localparam int IDX_W = $clog2(MAX_BREAKPOINTS);
	localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);

	localparam logic [2:0] TM_NONE = 3'd0;
	localparam logic [2:0] TM_LN   = 3'd1;
	localparam logic [2:0] TM_LN1  = 3'd2;
	localparam logic [2:0] TM_LN3  = 3'd3;
	localparam logic [2:0] TM_ADD3 = 3'd4;

	localparam logic [2:0] CFG_TRANSFORM = 3'd0;
	localparam logic [2:0] CFG_DIRECT    = 3'd1;
	localparam logic [2:0] CFG_MIN       = 3'd2;
	localparam logic [2:0] CFG_MAX       = 3'd3;
	localparam logic [2:0] CFG_COUNT     = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [27:0] LN2_Q28 = 28'd186065280;
	localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
	localparam logic signed [32:0] THREE_Q16 = 33'sd196608;

	typedef struct packed {
		logic              op;
		logic [3:0]        entry_index;
		logic signed [31:0] limit_value;
		logic signed [31:0] penalty_value;
		logic signed [31:0] query_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] penalty;
		logic              out_of_range;
		logic signed [31:0] raw_value;
	} out_t;

	typedef struct packed {
		logic [2:0]  transform_mode;
		logic        direct_value_mode;
		logic [14:0] min_length;
		logic [14:0] max_length;
		logic [4:0]  breakpoint_count;
	} cfg_t;

endpackage

// ----- design/plpl_seq.sv -----
`include "piecewise_linear_penalty_lookup_core_assert.svh"

module plpl_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          ready,
	input  plpl_pkg::in_t  item,
	input  plpl_pkg::cfg_t cfg,
	output logic          res_valid,
	input  logic          res_ready,
	output plpl_pkg::out_t res
);
	import plpl_pkg::*;

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_NORM  = 15'b000000000000010,
		ST_SQ    = 15'b000000000000100,
		ST_ABS   = 15'b000000000001000,
		ST_MLO   = 15'b000000000010000,
		ST_MHI   = 15'b000000000100000,
		ST_CNT   = 15'b000000001000000,
		ST_CLAST = 15'b000000010000000,
		ST_RDLO  = 15'b000000100000000,
		ST_RDHI  = 15'b000001000000000,
		ST_CHK   = 15'b000010000000000,
		ST_MUL   = 15'b000100000000000,
		ST_DIV   = 15'b001000000000000,
		ST_FIX   = 15'b010000000000000,
		ST_DONE  = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	logic [4:0]               cnt_q;
	logic signed [31:0]       v_q;
	logic [31:0]              u_q;
	logic [4:0]               p_q;
	logic [30:0]              m_q;
	logic [29:0]              frac_q;
	logic                     neg_q;
	logic [34:0]              mag_q;
	logic [63:0]              acc_q;
	logic [CNT_W-1:0]         idx_q, k_q, n_q;
	logic                     rdv_q;
	logic signed [31:0]       rd_lim_q, rd_pen_q, lo_q, p0_q;
	logic [31:0]              t_q, den_q, dmag_q, rem_q, lowq_q;
	logic                     dneg_q;
	out_t                     res_q;

	logic signed [31:0] lim_mem [MAX_BREAKPOINTS];
	logic signed [31:0] pen_mem [MAX_BREAKPOINTS];
	logic [IDX_W-1:0]   rd_addr;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	// request decode
	logic signed [31:0] q_w, raw_w, sat_w;
	logic               flag_w, is_ln_w, a_le0_w;
	logic signed [32:0] x_w, add_w, a_w;
	logic [CNT_W-1:0]   n_w;

	logic [31:0] nu_w;
	logic [4:0]  np_w;
	logic [31:0] msq_w;
	logic [5:0]  pm_w;
	logic [35:0] l2_w, l2n_w;
	logic [63:0] sum_w;
	logic [31:0] ln_mag_w, ln_v_w;
	logic        cmp_hit_w;
	logic signed [32:0] diff_w;
	logic [32:0] diff_neg_w;
	logic [32:0] trial_w;
	logic        ge_w;
	logic [33:0] p0e_w, q34_w, val_w;

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_comb begin
		q_w = item.query_value;
		if (q_w > 32'sd32767) begin
			sat_w = 32'sh7FFFFFFF;
		end else if (q_w < -32'sd32768) begin
			sat_w = 32'sh80000000;
		end else begin
			sat_w = {q_w[15:0], 16'h0000};
		end
		raw_w  = cfg.direct_value_mode ? q_w : sat_w;
		flag_w = !cfg.direct_value_mode &&
			((q_w < $signed({17'b0, cfg.min_length})) ||
			 (q_w > $signed({17'b0, cfg.max_length})));
		x_w = cfg.direct_value_mode ? {q_w[31], q_w} : {1'b0, q_w[15:0], 16'h0000};
		case (cfg.transform_mode)
			TM_LN1:  add_w = ONE_Q16;
			TM_LN3:  add_w = THREE_Q16;
			TM_ADD3: add_w = THREE_Q16;
			default: add_w = '0;
		endcase
		a_w     = x_w + add_w;
		is_ln_w = (cfg.transform_mode == TM_LN) || (cfg.transform_mode == TM_LN1) ||
			(cfg.transform_mode == TM_LN3);
		a_le0_w = a_w[32] || (a_w == '0);
		if (cfg.breakpoint_count == 5'd0) begin
			n_w = CNT_W'(1);
		end else if (cfg.breakpoint_count > MAX_BREAKPOINTS) begin
			n_w = CNT_W'(MAX_BREAKPOINTS);
		end else begin
			n_w = CNT_W'(cfg.breakpoint_count);
		end
	end

	// msb search, halving the shift each step
	always_comb begin
		nu_w = u_q;
		np_w = p_q;
		case (cnt_q)
			5'd0: if (u_q[31:16] == '0) begin nu_w = {u_q[15:0], 16'h0}; np_w = p_q - 5'd16; end
			5'd1: if (u_q[31:24] == '0) begin nu_w = {u_q[23:0], 8'h0}; np_w = p_q - 5'd8; end
			5'd2: if (u_q[31:28] == '0) begin nu_w = {u_q[27:0], 4'h0}; np_w = p_q - 5'd4; end
			5'd3: if (u_q[31:30] == '0) begin nu_w = {u_q[29:0], 2'b0}; np_w = p_q - 5'd2; end
			default: if (!u_q[31]) begin nu_w = {u_q[30:0], 1'b0}; np_w = p_q - 5'd1; end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			ST_MLO: begin
				mul_a = mag_q[31:0];
				mul_b = {4'b0, LN2_Q28};
			end
			ST_MHI: begin
				mul_a = {29'b0, mag_q[34:32]};
				mul_b = {4'b0, LN2_Q28};
			end
			ST_MUL: begin
				mul_a = dmag_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		msq_w    = mul_p[61:30];
		pm_w     = {1'b0, p_q} - 6'd16;
		l2_w     = {pm_w, frac_q};
		l2n_w    = ~l2_w + 36'd1;
		// ln2 scaling rounds half away from zero on the magnitude
		sum_w    = acc_q + {mul_p[31:0], 32'h0} + (64'd1 << 41);
		ln_mag_w = {10'b0, sum_w[63:42]};
		ln_v_w   = neg_q ? (~ln_mag_w + 32'd1) : ln_mag_w;
		cmp_hit_w = (rd_lim_q <= v_q);
		diff_w   = {rd_pen_q[31], rd_pen_q} - {p0_q[31], p0_q};
		diff_neg_w = ~diff_w + 33'd1;
		trial_w  = {rem_q, lowq_q[31]};
		ge_w     = (trial_w >= {1'b0, den_q});
		p0e_w    = {{2{p0_q[31]}}, p0_q};
		q34_w    = {2'b0, lowq_q};
		val_w    = dneg_q ? (p0e_w - q34_w) : (p0e_w + q34_w);
		if (rem_q != '0) begin
			if (!dneg_q && val_w[33]) begin
				val_w = val_w + 34'd1;
			end else if (dneg_q && !val_w[33] && (val_w != '0)) begin
				val_w = val_w - 34'd1;
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_RDLO: rd_addr = (k_q == '0) ? '0 : IDX_W'(k_q - CNT_W'(1));
			ST_RDHI: rd_addr = IDX_W'(k_q);
			default: rd_addr = IDX_W'(idx_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && item.op == OP_WRITE) begin
			lim_mem[IDX_W'(item.entry_index)] <= item.limit_value;
			pen_mem[IDX_W'(item.entry_index)] <= item.penalty_value;
		end
		rd_lim_q <= lim_mem[rd_addr];
		rd_pen_q <= pen_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.op == OP_WRITE || flag_w) begin
						state_d = ST_DONE;
					end else if (is_ln_w && !a_le0_w) begin
						state_d = ST_NORM;
					end else begin
						state_d = ST_CNT;
					end
				end
			end
			ST_NORM:  if (cnt_q == 5'd4) state_d = ST_SQ;
			ST_SQ:    if (cnt_q == 5'd29) state_d = ST_ABS;
			ST_ABS:   state_d = ST_MLO;
			ST_MLO:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_CNT;
			ST_CNT:   if (idx_q == n_q - CNT_W'(1)) state_d = ST_CLAST;
			ST_CLAST: state_d = ST_RDLO;
			ST_RDLO:  state_d = ST_RDHI;
			ST_RDHI:  state_d = ST_CHK;
			ST_CHK: begin
				if (k_q == '0 || k_q == n_q || !(lo_q <= v_q && v_q < rd_lim_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (cnt_q == 5'd31) state_d = ST_FIX;
			ST_FIX:   state_d = ST_DONE;
			ST_DONE:  if (res_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cnt_q <= '0;
				idx_q <= '0;
				k_q   <= '0;
				rdv_q <= 1'b0;
				n_q   <= n_w;
				p_q   <= 5'd31;
				u_q   <= a_w[31:0];
				res_q.penalty      <= '0;
				res_q.out_of_range <= (item.op == OP_QUERY) && flag_w;
				res_q.raw_value    <= (item.op == OP_QUERY) ? raw_w : '0;
				if (is_ln_w) begin
					v_q <= 32'sh80000000;
				end else if (cfg.transform_mode == TM_ADD3) begin
					v_q <= (a_w[32] != a_w[31]) ? 32'sh7FFFFFFF : a_w[31:0];
				end else begin
					v_q <= x_w[31:0];
				end
			end
			ST_NORM: begin
				u_q   <= nu_w;
				p_q   <= np_w;
				m_q   <= nu_w[31:1];
				frac_q <= '0;
				cnt_q <= (cnt_q == 5'd4) ? 5'd0 : cnt_q + 5'd1;
			end
			ST_SQ: begin
				if (msq_w[31]) begin
					m_q    <= msq_w[31:1];
					frac_q <= {frac_q[28:0], 1'b1};
				end else begin
					m_q    <= msq_w[30:0];
					frac_q <= {frac_q[28:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
			end
			ST_ABS: begin
				neg_q <= pm_w[5];
				mag_q <= pm_w[5] ? l2n_w[34:0] : l2_w[34:0];
			end
			ST_MLO: acc_q <= mul_p;
			ST_MHI: v_q <= ln_v_w;
			ST_CNT: begin
				rdv_q <= 1'b1;
				idx_q <= idx_q + CNT_W'(1);
				if (rdv_q && cmp_hit_w) k_q <= k_q + CNT_W'(1);
			end
			ST_CLAST: if (cmp_hit_w) k_q <= k_q + CNT_W'(1);
			ST_RDHI: begin
				lo_q <= rd_lim_q;
				p0_q <= rd_pen_q;
			end
			ST_CHK: begin
				res_q.penalty <= p0_q;
				t_q    <= v_q - lo_q;
				den_q  <= rd_lim_q - lo_q;
				dneg_q <= diff_w[32];
				dmag_q <= diff_w[32] ? diff_neg_w[31:0] : diff_w[31:0];
				cnt_q  <= '0;
			end
			ST_MUL: begin
				rem_q  <= mul_p[63:32];
				lowq_q <= mul_p[31:0];
			end
			ST_DIV: begin
				rem_q  <= ge_w ? 32'(trial_w - {1'b0, den_q}) : trial_w[31:0];
				lowq_q <= {lowq_q[30:0], ge_w};
				cnt_q  <= cnt_q + 5'd1;
			end
			ST_FIX: res_q.penalty <= val_w[31:0];
			default: begin
			end
		endcase
	end

	`PLPL_ASSERT_IMP(a_start_idle, clk, arst_n, start, state_q == ST_IDLE, "request taken while busy")
	`PLPL_ASSERT_IMP(a_sq_norm, clk, arst_n, state_q == ST_SQ, m_q[30], "log mantissa lost normalization")
	`PLPL_ASSERT_IMP(a_div_rem, clk, arst_n, state_q == ST_DIV, rem_q < den_q, "divider remainder not below divisor")
	`PLPL_ASSERT_IMP(a_k_bound, clk, arst_n, state_q == ST_CHK, k_q <= n_q, "limit count exceeds entries in use")

endmodule

// ----- design/piecewise_linear_penalty_lookup_core.sv -----
// piecewise-linear penalty lookup over a table of up to 16 breakpoints
// in: in_valid/in_ready with in_data; op selects breakpoint write or query
// out: out_valid/out_ready with out_data; exactly one result per request
// cfg: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready, and
//   registers are meant to change only while no request is in flight
// a write request, or a query whose length is flagged, goes straight to the result
// a query runs on one shared 32x32 multiplier and a restoring divider:
//   msb search, 30 squaring steps and ln2 scaling for ln transforms,
//   a count of limits at or below the value and a fetch of the pair,
//   then a multiply, 32 divider steps and a rounding fix when the value falls inside a pair
// one request is in flight at a time; in_ready is low until its result
//   has moved into the output register
// the output register holds a result until out_ready; the next request is
//   accepted meanwhile, and its result waits for the register to free
// reset clears the configuration (breakpoint_count to 1) and the handshake;
//   breakpoint entries are undefined until written
module piecewise_linear_penalty_lookup_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  plpl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output plpl_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import plpl_pkg::*;

	cfg_t cfg_q;
	logic out_valid_q;
	out_t out_data_q;
	logic res_valid, res_ready;
	out_t res;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transform_mode    <= TM_NONE;
			cfg_q.direct_value_mode <= 1'b0;
			cfg_q.min_length        <= '0;
			cfg_q.max_length        <= '0;
			cfg_q.breakpoint_count  <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRANSFORM: cfg_q.transform_mode    <= cfg_data[2:0];
				CFG_DIRECT:    cfg_q.direct_value_mode <= cfg_data[0];
				CFG_MIN:       cfg_q.min_length        <= cfg_data[14:0];
				CFG_MAX:       cfg_q.max_length        <= cfg_data[14:0];
				CFG_COUNT:     cfg_q.breakpoint_count  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	plpl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.ready     (in_ready),
		.item      (in_data),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

endmodule

// ----- bench/piecewise_linear_penalty_lookup_core_tb.sv -----
module piecewise_linear_penalty_lookup_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plpl_pkg::*;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0]  cfg_index = CFG_TRANSFORM;
	logic [31:0] cfg_data = '0;

	piecewise_linear_penalty_lookup_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// mirror of the block's registers and breakpoint table
	logic [2:0]  m_transform = TM_NONE;
	logic        m_direct = 1'b0;
	logic [14:0] m_min_len = '0;
	logic [14:0] m_max_len = '0;
	logic [4:0]  m_bp_count = 5'd1;
	longint      m_limit [MAX_BREAKPOINTS];
	longint      m_penalty [MAX_BREAKPOINTS];

	out_t   pending_penalties[$];
	int     error_count = 0;
	int     gap_pct = 0;
	int     stall_pct = 0;
	bit     cur_typed = 1'b0;
	out_t   cur_want = '0;
	row_t   directed_rows[$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// log2 by repeated squaring, scaled by ln2 and rounded to q16.16
	function automatic longint fixed_ln(longint a);
		longint unsigned u, m, frac, mag, prod, r;
		int p;
		longint l2;
		if (a <= 0) return -64'sd2147483648;
		u = a;
		p = 0;
		frac = 0;
		while (p < 62 && (u >> (p + 1)) != 0) p++;
		m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		l2 = (longint'(p) - 16) * (64'sd1 <<< 30) + longint'(frac);
		mag = (l2 < 0) ? -l2 : l2;
		prod = mag * 64'd186065280;
		r = (prod + (64'd1 << 41)) >> 42;
		return (l2 < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint interpolate_penalty(longint v);
		int n, k;
		longint lo, hi;
		logic signed [127:0] num, den, pa, pb;
		n = int'(m_bp_count);
		k = 0;
		if (n < 1) n = 1;
		if (n > MAX_BREAKPOINTS) n = MAX_BREAKPOINTS;
		for (int i = 0; i < n; i++)
			if (m_limit[i] <= v) k++;
		if (k == 0) return m_penalty[0];
		if (k == n) return m_penalty[n-1];
		lo = m_limit[k-1];
		hi = m_limit[k];
		// limits out of order: hold the penalty of the lower breakpoint
		if (!(lo <= v && v < hi)) return m_penalty[k-1];
		pa = 128'(m_penalty[k]);
		pb = 128'(m_penalty[k-1]);
		num = pa * (v - lo) + pb * (hi - v);
		den = 128'(hi - lo);
		return longint'(num / den);
	endfunction

	function automatic out_t predict_penalty(in_t req);
		out_t o;
		longint q, x, v;
		o = '0;
		if (req.op == OP_WRITE) begin
			m_limit[req.entry_index] = longint'(req.limit_value);
			m_penalty[req.entry_index] = longint'(req.penalty_value);
			return o;
		end
		q = longint'(req.query_value);
		if (m_direct) begin
			o.raw_value = req.query_value;
			x = q;
		end else begin
			o.raw_value = 32'(sat32(q * 65536));
			if (q < longint'(m_min_len) || q > longint'(m_max_len)) begin
				o.out_of_range = 1'b1;
				return o;
			end
			x = q * 65536;
		end
		case (m_transform)
			TM_LN:   v = fixed_ln(x);
			TM_LN1:  v = fixed_ln(x + 65536);
			TM_LN3:  v = fixed_ln(x + 196608);
			TM_ADD3: v = sat32(x + 196608);
			default: v = x;
		endcase
		o.penalty = 32'(interpolate_penalty(v));
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t %s: got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRANSFORM: m_transform = cfg_data[2:0];
					CFG_DIRECT:    m_direct = cfg_data[0];
					CFG_MIN:       m_min_len = cfg_data[14:0];
					CFG_MAX:       m_max_len = cfg_data[14:0];
					CFG_COUNT:     m_bp_count = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = predict_penalty(in_data);
				pending_penalties.push_back(cur_typed ? cur_want : want);
			end
			if (out_valid && out_ready) begin
				if (pending_penalties.size() == 0) begin
					report_mismatch("result with no request",
						longint'(out_data.penalty), 64'sd0);
				end else begin
					want = pending_penalties.pop_front();
					if (out_data.penalty !== want.penalty)
						report_mismatch("penalty", longint'(out_data.penalty),
							longint'(want.penalty));
					if (out_data.out_of_range !== want.out_of_range)
						report_mismatch("out_of_range", longint'(out_data.out_of_range),
							longint'(want.out_of_range));
					if (out_data.raw_value !== want.raw_value)
						report_mismatch("raw_value", longint'(out_data.raw_value),
							longint'(want.raw_value));
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_request(in_t req, bit typed = 1'b0, out_t want = '0);
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		cur_typed = typed;
		cur_want = want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_penalties.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_t query_req(logic [31:0] value);
		in_t r;
		r = '0;
		r.op = OP_QUERY;
		r.query_value = value;
		r.limit_value = $urandom;
		r.penalty_value = $urandom;
		r.entry_index = 4'($urandom);
		return r;
	endfunction

	function automatic in_t write_req(int idx, longint lim, longint pen);
		in_t r;
		r = '0;
		r.op = OP_WRITE;
		r.entry_index = 4'(idx);
		r.limit_value = 32'(lim);
		r.penalty_value = 32'(pen);
		r.query_value = $urandom;
		return r;
	endfunction

	longint tbl_base;
	longint tbl_top;

	// ascending table most of the time, scrambled now and then
	task automatic load_table();
		int sh;
		longint lim;
		sh = $urandom_range(12, 27);
		lim = -longint'($urandom_range(0, 1 << sh));
		tbl_base = lim;
		for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_request(write_req(i, longint'($signed($urandom)),
					longint'($signed($urandom))));
			else
				send_request(write_req(i, lim,
					($urandom_range(0, 7) == 0) ? $signed($urandom)
						: longint'($urandom_range(0, 1 << 24)) - (1 << 23)));
			lim += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << (sh - 2));
		end
		tbl_top = lim;
	endtask

	function automatic logic [31:0] pick_query();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom;
		if (m_direct) begin
			if (sel < 4)
				return 32'(m_limit[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2);
			if (sel < 6) return $urandom_range(0, 1 << 22);
			return 32'(tbl_base - 1000 + longint'($urandom_range(0,
				32'(tbl_top - tbl_base + 2000))));
		end
		if (m_min_len <= m_max_len && sel < 8)
			return m_min_len + $urandom_range(0, m_max_len - m_min_len);
		return 32'(longint'(m_min_len) + $urandom_range(0, 6) - 3);
	endfunction

	initial begin
		row_t row;
		logic [2:0]  c_tm;
		logic        c_dir;
		logic [14:0] c_min, c_max;
		logic [4:0]  c_cnt;
		for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
			m_limit[i] = '0;
			m_penalty[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fill the table, then queries at reset configuration
		for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
			row.req = write_req(i, longint'(i - 8) * (1 << 18),
				longint'((i == 0) ? 32'sh8000_0000 : (i == 15) ? 32'sh7fff_ffff
					: i * 1000 - 5000));
			row.typed = 1'b1;
			row.want = '0;
			directed_rows.push_back(row);
		end
		row.typed = 1'b0;
		row.req = query_req(32'd0);
		directed_rows.push_back(row);
		row.typed = 1'b1;
		row.want = '{penalty: 32'sd0, out_of_range: 1'b1, raw_value: 32'sd65536};
		row.req = query_req(32'd1);
		directed_rows.push_back(row);
		row.want.raw_value = -32'sd65536;
		row.req = query_req(32'hffff_ffff);
		directed_rows.push_back(row);
		row.want.raw_value = 32'sh7fff_ffff;
		row.req = query_req(32'h7fff_ffff);
		directed_rows.push_back(row);
		row.want.raw_value = 32'sh8000_0000;
		row.req = query_req(32'h8000_0000);
		directed_rows.push_back(row);
		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		drain_results();
		tbl_base = -longint'(8 << 18);
		tbl_top = longint'(7 << 18);

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 86; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 86; end
				default: begin gap_pct = 11; stall_pct = 11; end
			endcase
			c_tm = 3'($urandom_range(0, 7));
			c_dir = 1'($urandom);
			c_min = 15'($urandom_range(0, 200));
			c_max = 15'(c_min + $urandom_range(0, 400));
			c_cnt = 5'($urandom_range(1, 16));
			case (ph)
				0: begin c_tm = TM_NONE; c_dir = 1'b1; c_min = 15'd0; c_max = 15'h7fff;
					c_cnt = 5'd16; end
				1: begin c_tm = TM_LN; c_dir = 1'b0; c_cnt = 5'd16; end
				2: begin c_tm = TM_LN1; c_dir = 1'b1; c_cnt = 5'd0; end
				3: begin c_tm = TM_LN3; c_dir = 1'b0; c_min = 15'h7fff; c_max = 15'h7fff;
					c_cnt = 5'd31; end
				4: begin c_tm = TM_ADD3; c_dir = 1'b1; c_cnt = 5'd16; end
				5: begin c_tm = 3'd7; c_dir = 1'b0; c_min = 15'd500; c_max = 15'd10;
					c_cnt = 5'd5; end
				6: begin c_tm = TM_LN; c_dir = 1'b1; end
				default: if ($urandom_range(0, 3) == 0) c_cnt = 5'($urandom_range(0, 31));
			endcase
			write_reg(CFG_TRANSFORM, 32'(c_tm));
			write_reg(CFG_DIRECT, 32'(c_dir));
			write_reg(CFG_MIN, 32'(c_min));
			write_reg(CFG_MAX, 32'(c_max));
			write_reg(CFG_COUNT, 32'(c_cnt));
			load_table();
			for (int n = 0; n < 29; n++) begin
				if ($urandom_range(0, 19) == 0)
					send_request(write_req($urandom_range(0, 15),
						longint'($signed($urandom)), longint'($signed($urandom))));
				else
					send_request(query_req(pick_query()));
			end
			drain_results();
		end

		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("piecewise_linear_penalty_lookup_core: match");
		else
			$display("piecewise_linear_penalty_lookup_core: mismatch");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("piecewise_linear_penalty_lookup_core: mismatch");
		$finish;
	end

endmodule
